// ===== design/frba_pkg.sv =====
// ----------------------------------------------------------------------------
// frba_pkg
// Shared command/status types and codes for the fenced ring buffer allocator.
// ----------------------------------------------------------------------------
package frba_pkg;

  // result status codes
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_TOO_LARGE  = 3'd1;
  localparam logic [2:0] ST_FLUSH      = 3'd2;
  localparam logic [2:0] ST_TABLE_FULL = 3'd3;
  localparam logic [2:0] ST_BAD_COMMIT = 3'd4;

  // datapath command codes
  localparam logic [3:0] CMD_NONE     = 4'd0;
  localparam logic [3:0] CMD_LATCH    = 4'd1;
  localparam logic [3:0] CMD_COMMIT   = 4'd2;
  localparam logic [3:0] CMD_FINISH   = 4'd3;
  localparam logic [3:0] CMD_RD_TAIL  = 4'd4;
  localparam logic [3:0] CMD_UPD_TAIL = 4'd5;
  localparam logic [3:0] CMD_RD_HEAD  = 4'd6;
  localparam logic [3:0] CMD_RETIRE   = 4'd7;
  localparam logic [3:0] CMD_PUSH     = 4'd8;
  localparam logic [3:0] CMD_FAST     = 4'd9;
  localparam logic [3:0] CMD_K_CLR    = 4'd10;
  localparam logic [3:0] CMD_RD_K     = 4'd11;
  localparam logic [3:0] CMD_K_INC    = 4'd12;
  localparam logic [3:0] CMD_TAKE     = 4'd13;

  typedef struct packed {
    logic [3:0] code;
    logic [2:0] fin_status;
  } frba_cmd_t;

  typedef struct packed {
    logic is_commit;
    logic too_large;
    logic trivial;
    logic cnt_zero;
    logic tail_match;
    logic can_retire;
    logic table_full;
    logic fast_ok;
    logic k_end;
    logic hit;
    logic hit_cur;
  } frba_stat_t;

endpackage

// ===== design/frba_ctrl.sv =====
// ----------------------------------------------------------------------------
// frba_ctrl
// Sequencer: commit, or record fence, retire, push, place, then search the fence table.
// ----------------------------------------------------------------------------
module frba_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  frba_pkg::frba_stat_t stat_i,
  output frba_pkg::frba_cmd_t  cmd_o
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_CHK      = 4'd1;
  localparam logic [3:0] S_TAIL_CHK = 4'd2;
  localparam logic [3:0] S_RET_RD   = 4'd3;
  localparam logic [3:0] S_RET_CHK  = 4'd4;
  localparam logic [3:0] S_PUSH     = 4'd5;
  localparam logic [3:0] S_PLACE    = 4'd6;
  localparam logic [3:0] S_SRCH_RD  = 4'd7;
  localparam logic [3:0] S_SRCH_CHK = 4'd8;

  logic [3:0] state_q, state_d;

  assign busy = (state_q != S_IDLE);

  // next state and command
  always_comb begin
    state_d = state_q;
    cmd_o.code = frba_pkg::CMD_NONE;
    cmd_o.fin_status = frba_pkg::ST_OK;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.code = frba_pkg::CMD_LATCH;
          state_d = S_CHK;
        end
      end
      S_CHK: begin
        if (stat_i.is_commit) begin
          cmd_o.code = frba_pkg::CMD_COMMIT;
          state_d = S_IDLE;
        end else if (stat_i.too_large) begin
          cmd_o.code = frba_pkg::CMD_FINISH;
          cmd_o.fin_status = frba_pkg::ST_TOO_LARGE;
          state_d = S_IDLE;
        end else if (stat_i.trivial) begin
          state_d = S_PLACE;
        end else if (stat_i.cnt_zero) begin
          state_d = S_RET_RD;
        end else begin
          cmd_o.code = frba_pkg::CMD_RD_TAIL;
          state_d = S_TAIL_CHK;
        end
      end
      S_TAIL_CHK: begin
        if (stat_i.tail_match) begin
          cmd_o.code = frba_pkg::CMD_UPD_TAIL;
          state_d = S_PLACE;
        end else begin
          state_d = S_RET_RD;
        end
      end
      S_RET_RD: begin
        if (stat_i.cnt_zero) begin
          state_d = S_PUSH;
        end else begin
          cmd_o.code = frba_pkg::CMD_RD_HEAD;
          state_d = S_RET_CHK;
        end
      end
      S_RET_CHK: begin
        if (stat_i.can_retire) begin
          cmd_o.code = frba_pkg::CMD_RETIRE;
          state_d = S_RET_RD;
        end else begin
          state_d = S_PUSH;
        end
      end
      S_PUSH: begin
        if (stat_i.table_full) begin
          cmd_o.code = frba_pkg::CMD_FINISH;
          cmd_o.fin_status = frba_pkg::ST_TABLE_FULL;
          state_d = S_IDLE;
        end else begin
          cmd_o.code = frba_pkg::CMD_PUSH;
          state_d = S_PLACE;
        end
      end
      S_PLACE: begin
        if (stat_i.fast_ok) begin
          cmd_o.code = frba_pkg::CMD_FAST;
          state_d = S_IDLE;
        end else begin
          cmd_o.code = frba_pkg::CMD_K_CLR;
          state_d = S_SRCH_RD;
        end
      end
      S_SRCH_RD: begin
        if (stat_i.k_end) begin
          cmd_o.code = frba_pkg::CMD_FINISH;
          cmd_o.fin_status = frba_pkg::ST_FLUSH;
          state_d = S_IDLE;
        end else begin
          cmd_o.code = frba_pkg::CMD_RD_K;
          state_d = S_SRCH_CHK;
        end
      end
      S_SRCH_CHK: begin
        if (!stat_i.hit) begin
          cmd_o.code = frba_pkg::CMD_K_INC;
          state_d = S_SRCH_RD;
        end else if (stat_i.hit_cur) begin
          cmd_o.code = frba_pkg::CMD_FINISH;
          cmd_o.fin_status = frba_pkg::ST_FLUSH;
          state_d = S_IDLE;
        end else begin
          cmd_o.code = frba_pkg::CMD_TAKE;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== design/frba_datapath.sv =====
// ----------------------------------------------------------------------------
// frba_datapath
// Allocator registers, fence table memory and the compare/align logic.
// ----------------------------------------------------------------------------
module frba_datapath #(
  parameter int FENCE_SLOTS = 16,
  parameter int OFFSET_BITS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [31:0]          cfg_wdata_i,
  input  logic                 action_i,
  input  logic [31:0]          byte_count_i,
  input  logic [16:0]          align_bytes_i,
  input  logic [63:0]          current_fence_i,
  input  logic [63:0]          completed_fence_i,
  input  frba_pkg::frba_cmd_t  cmd_i,
  output frba_pkg::frba_stat_t stat_o,
  output logic                 done_o,
  output logic [2:0]           status_o,
  output logic [31:0]          place_offset_o,
  output logic                 wait_valid_o,
  output logic [63:0]          wait_fence_o
);

  localparam int HW = (FENCE_SLOTS > 1) ? $clog2(FENCE_SLOTS) : 1;
  localparam int CW = $clog2(FENCE_SLOTS + 1);
  localparam int SW = HW + 1;
  localparam int OB = OFFSET_BITS;
  localparam int EW = 64 + OB;

  // allocator state
  logic [31:0]   bsize_q;
  logic [OB-1:0] wo_q, wo_d;
  logic [OB-1:0] cp_q, cp_d;
  logic [31:0]   lrs_q, lrs_d;
  logic [HW-1:0] head_q, head_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] k_q, k_d;

  // latched item
  logic        act_q;
  logic [31:0] n_q;
  logic [16:0] a_q;
  logic [63:0] cur_q;
  logic [63:0] cmp_q;

  // fence table
  logic [EW-1:0] mem_q [FENCE_SLOTS];
  logic [EW-1:0] rd_q;
  logic          mem_we;
  logic [HW-1:0] mem_wa;
  logic [EW-1:0] mem_wd;
  logic          mem_re;
  logic [HW-1:0] mem_ra;

  // result beat
  logic        done_q;
  logic [2:0]  st_q;
  logic        wv_q;
  logic [63:0] wf_q;

  logic [63:0]   rd_val;
  logic [OB-1:0] rd_off;
  logic [32:0]   req;
  logic [32:0]   wo33, cp33, gp33, bs33;
  logic [32:0]   room_wo;
  logic [OB-1:0] wo_aligned;
  logic [32:0]   commit_sum;
  logic          eq, gt, hit_a, hit_b, hit_lt;
  logic [OB-1:0] take_no, take_ng;
  logic [CW-1:0] drop_n;
  logic [CW-1:0] cnt_m1;

  // ring index of head + x
  function automatic logic [HW-1:0] slot_of(input logic [HW-1:0] h, input logic [CW-1:0] x);
    logic [SW-1:0] s;
    s = SW'(h) + SW'(x);
    if (s >= SW'(FENCE_SLOTS)) begin
      s = s - SW'(FENCE_SLOTS);
    end
    return s[HW-1:0];
  endfunction

  // round offset up to alignment, masked to offset width
  function automatic logic [OB-1:0] align_up(input logic [OB-1:0] off, input logic [16:0] a);
    logic [33:0] am1;
    logic [33:0] t;
    am1 = 34'(a) - 34'd1;
    t = (34'(off) + am1) & ~am1;
    return t[OB-1:0];
  endfunction

  assign rd_val = rd_q[EW-1:OB];
  assign rd_off = rd_q[OB-1:0];
  assign req = 33'(n_q) + 33'(a_q);
  assign wo33 = 33'(wo_q);
  assign cp33 = 33'(cp_q);
  assign gp33 = 33'(rd_off);
  assign bs33 = 33'(bsize_q);
  assign room_wo = (wo33 <= bs33) ? (bs33 - wo33) : 33'd0;
  assign wo_aligned = align_up(wo_q, a_q);
  assign commit_sum = wo33 + 33'(n_q);
  assign cnt_m1 = cnt_q - CW'(1);

  // search hit for the entry just read
  assign eq = (wo_q == rd_off);
  assign gt = (wo_q > rd_off);
  assign hit_a = gt && (room_wo >= req);
  assign hit_b = gt && (gp33 > req);
  assign hit_lt = !eq && !gt && ((gp33 - wo33) > req);
  assign take_no = (eq || (gt && !hit_a)) ? '0 : wo_q;
  assign take_ng = eq ? '0 : rd_off;
  assign drop_n = eq ? cnt_q : (k_q + CW'(1));

  // status toward the sequencer
  always_comb begin
    stat_o.is_commit = act_q;
    stat_o.too_large = (req > bs33);
    stat_o.trivial = (wo_q == cp_q);
    stat_o.cnt_zero = (cnt_q == '0);
    stat_o.tail_match = (rd_val == cur_q);
    stat_o.can_retire = (cmp_q >= rd_val);
    stat_o.table_full = (cnt_q >= CW'(FENCE_SLOTS));
    if (wo_q >= cp_q) begin
      stat_o.fast_ok = (req <= room_wo) || (req < cp33);
    end else begin
      stat_o.fast_ok = (req < (cp33 - wo33));
    end
    stat_o.k_end = (k_q >= cnt_q);
    stat_o.hit = eq || hit_a || hit_b || hit_lt;
    stat_o.hit_cur = (rd_val == cur_q);
  end

  // memory port control
  always_comb begin
    mem_we = 1'b0;
    mem_wa = slot_of(head_q, cnt_q);
    mem_wd = {cur_q, wo_q};
    mem_re = 1'b0;
    mem_ra = head_q;
    case (cmd_i.code)
      frba_pkg::CMD_RD_TAIL: begin
        mem_re = 1'b1;
        mem_ra = slot_of(head_q, cnt_m1);
      end
      frba_pkg::CMD_RD_HEAD: begin
        mem_re = 1'b1;
      end
      frba_pkg::CMD_RD_K: begin
        mem_re = 1'b1;
        mem_ra = slot_of(head_q, k_q);
      end
      frba_pkg::CMD_UPD_TAIL: begin
        mem_we = 1'b1;
        mem_wa = slot_of(head_q, cnt_m1);
      end
      frba_pkg::CMD_PUSH: begin
        mem_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_q <= mem_q[mem_ra];
    end
  end

  // state updates per command
  always_comb begin
    wo_d = wo_q;
    cp_d = cp_q;
    lrs_d = lrs_q;
    head_d = head_q;
    cnt_d = cnt_q;
    k_d = k_q;
    case (cmd_i.code)
      frba_pkg::CMD_COMMIT: begin
        if (!((commit_sum > bs33) || (n_q > lrs_q))) begin
          wo_d = commit_sum[OB-1:0];
        end
      end
      frba_pkg::CMD_RETIRE: begin
        cp_d = rd_off;
        head_d = slot_of(head_q, CW'(1));
        cnt_d = cnt_m1;
      end
      frba_pkg::CMD_PUSH: begin
        cnt_d = cnt_q + CW'(1);
      end
      frba_pkg::CMD_FAST: begin
        lrs_d = n_q;
        if (wo_q >= cp_q && !(req <= room_wo)) begin
          wo_d = '0;
        end else begin
          wo_d = wo_aligned;
        end
      end
      frba_pkg::CMD_K_CLR: begin
        k_d = '0;
      end
      frba_pkg::CMD_K_INC: begin
        k_d = k_q + CW'(1);
      end
      frba_pkg::CMD_TAKE: begin
        lrs_d = n_q;
        wo_d = align_up(take_no, a_q);
        cp_d = take_ng;
        head_d = slot_of(head_q, drop_n);
        cnt_d = cnt_q - drop_n;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bsize_q <= '0;
      wo_q <= '0;
      cp_q <= '0;
      lrs_q <= '0;
      head_q <= '0;
      cnt_q <= '0;
      k_q <= '0;
      done_q <= 1'b0;
    end else if (cfg_we_i) begin
      bsize_q <= cfg_wdata_i;
      wo_q <= '0;
      cp_q <= '0;
      lrs_q <= '0;
      head_q <= '0;
      cnt_q <= '0;
      k_q <= '0;
      done_q <= 1'b0;
    end else begin
      wo_q <= wo_d;
      cp_q <= cp_d;
      lrs_q <= lrs_d;
      head_q <= head_d;
      cnt_q <= cnt_d;
      k_q <= k_d;
      done_q <= (cmd_i.code == frba_pkg::CMD_COMMIT) || (cmd_i.code == frba_pkg::CMD_FINISH) ||
                (cmd_i.code == frba_pkg::CMD_FAST) || (cmd_i.code == frba_pkg::CMD_TAKE);
    end
  end

  // item latch and result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.code == frba_pkg::CMD_LATCH) begin
      act_q <= action_i;
      n_q <= byte_count_i;
      a_q <= (align_bytes_i == '0) ? 17'd1 : align_bytes_i;
      cur_q <= current_fence_i;
      cmp_q <= completed_fence_i;
    end
    case (cmd_i.code)
      frba_pkg::CMD_COMMIT: begin
        st_q <= ((commit_sum > bs33) || (n_q > lrs_q)) ? frba_pkg::ST_BAD_COMMIT
                                                       : frba_pkg::ST_OK;
        wv_q <= 1'b0;
        wf_q <= '0;
      end
      frba_pkg::CMD_FINISH: begin
        st_q <= cmd_i.fin_status;
        wv_q <= 1'b0;
        wf_q <= '0;
      end
      frba_pkg::CMD_FAST: begin
        st_q <= frba_pkg::ST_OK;
        wv_q <= 1'b0;
        wf_q <= '0;
      end
      frba_pkg::CMD_TAKE: begin
        st_q <= frba_pkg::ST_OK;
        wv_q <= 1'b1;
        wf_q <= rd_val;
      end
      default: begin
      end
    endcase
  end

  assign done_o = done_q;
  assign status_o = st_q;
  assign place_offset_o = 32'(wo_q);
  assign wait_valid_o = wv_q;
  assign wait_fence_o = wf_q;

endmodule

// ===== design/fenced_ring_buffer_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// fenced_ring_buffer_allocator_unit
// Ring allocator for an upload buffer drained behind fences.
// A reserve takes longer for each retired fence and each searched entry, since
// the fence table has a single read port.
// One item at a time; busy stays high until the result beat is on done_o.
// The result beat lasts one cycle; the receiver cannot stall.
// Reset (or a buffer_size write) empties the fence table and zeroes offsets.
// ----------------------------------------------------------------------------
module fenced_ring_buffer_allocator_unit #(
  parameter int FENCE_SLOTS = 16,
  parameter int OFFSET_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        start,
  output logic        busy,
  input  logic        action_i,
  input  logic [31:0] byte_count_i,
  input  logic [16:0] align_bytes_i,
  input  logic [63:0] current_fence_i,
  input  logic [63:0] completed_fence_i,
  output logic        done_o,
  output logic [2:0]  status_o,
  output logic [31:0] place_offset_o,
  output logic        wait_valid_o,
  output logic [63:0] wait_fence_o
);

  frba_pkg::frba_cmd_t  cmd;
  frba_pkg::frba_stat_t stat;

  // sequencer
  frba_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  // registers, table and arithmetic
  frba_datapath #(
    .FENCE_SLOTS (FENCE_SLOTS),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .action_i          (action_i),
    .byte_count_i      (byte_count_i),
    .align_bytes_i     (align_bytes_i),
    .current_fence_i   (current_fence_i),
    .completed_fence_i (completed_fence_i),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .done_o            (done_o),
    .status_o          (status_o),
    .place_offset_o    (place_offset_o),
    .wait_valid_o      (wait_valid_o),
    .wait_fence_o      (wait_fence_o)
  );

  // a result beat only comes once the sequencer is back to idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("result beat while busy");

  // an accepted item keeps the unit busy next cycle
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && !cfg_we_i) |=> busy) else $error("accepted item not busy");

  // a wait request only comes with a successful reserve
  a_wait_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && wait_valid_o) |-> (status_o == frba_pkg::ST_OK))
    else $error("wait with error status");

endmodule
